/* rtl/b64c_pkg.sv */
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and alphabet functions of the base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

    // mode register values
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // pad character '='
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // items held in one group
    localparam int GROUP_BYTES = 4;

    // one group of work handed from the front to the back
    typedef struct packed {
        logic                               mode;    // encode or decode
        logic [GROUP_BYTES-1:0][7:0]        bytes;   // group, unfilled slots zero
        logic [2:0]                         n_data;  // chars before pad / bytes out
        logic                               last;    // message ends with this group
    } t_job;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // sextet to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'd65 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'd71 + {2'b00, s};
        end else if (s < 6'd62) begin
            c = {2'b00, s} - 8'd4;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // alphabet character to sextet, 255 for anything outside the alphabet
    function automatic logic [7:0] dec_sextet(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'd65;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'd71;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c + 8'd4;
        end else if (c == 8'h2B) begin
            v = 8'd62;
        end else if (c == 8'h2F) begin
            v = 8'd63;
        end else begin
            v = 8'd255;
        end
        return v;
    endfunction

endpackage

/* rtl/base64_codec_core.sv */
// ----------------------------------------------------------------------------
// base64_codec_core
// Streaming base64 encoder and decoder, mode selected by a one-bit register.
// ----------------------------------------------------------------------------
// Input items are taken at one per cycle while the queue has room. The front
// gathers a group and, when it is complete or the message ends, passes it
// through a QUEUE_DEPTH-entry queue to the back, which sends one result item
// per cycle, unless the output stalls, through an output register. Encoding
// turns three bytes into four characters, so a steady byte stream is limited
// by the output side; decoding runs at one character per cycle while the
// queue has room. A finished group is written into the queue, and its first
// result is then loaded into the output register. Writing the mode register
// drops any partial group; write it only while idle.
module base64_codec_core
    import b64c_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    // output stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,
    // mode register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    logic    push;
    logic    pop;
    t_job    job;
    t_job    head;
    t_q_stat q_stat;
    logic    cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // group collection
    b64c_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_byte     (i_s_tdata),
        .i_last     (i_s_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_mode (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (job)
    );

    // group queue
    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // result generation
    b64c_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_byte   (o_m_tdata),
        .o_last   (o_m_tlast)
    );

endmodule

/* rtl/b64c_front.sv */
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input items, gathers groups and hands finished groups to the queue.
// ----------------------------------------------------------------------------
module b64c_front
    import b64c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input item
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    // mode register write
    input  logic       i_cfg_we,
    input  logic       i_cfg_mode,
    // queue side
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_job       o_job
);

    logic                         r_mode;
    logic [1:0]                   r_cnt;
    logic                         r_pad;
    logic [GROUP_BYTES-1:0][7:0]  r_grp;

    logic       accept;
    logic       stored;
    logic       grp_full;
    logic       full;
    logic [2:0] cnt_after;
    logic       push;
    logic [1:0] n_cnt;
    logic       n_pad;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    // classify the item and build the group it may complete
    always_comb begin
        stored    = (r_mode == MODE_ENCODE) || (!r_pad && i_byte != CHAR_PAD);
        grp_full  = (r_mode == MODE_ENCODE) ? (r_cnt == 2'd2) : (r_cnt == 2'd3);
        full      = stored && grp_full;
        cnt_after = {1'b0, r_cnt} + {2'b00, stored};

        for (int i = 0; i < GROUP_BYTES; i++) begin
            if (i < r_cnt) begin
                o_job.bytes[i] = r_grp[i];
            end else if (i == r_cnt && stored) begin
                o_job.bytes[i] = i_byte;
            end else begin
                o_job.bytes[i] = 8'h00;
            end
        end
        o_job.mode = r_mode;
        o_job.last = i_last;

        if (r_mode == MODE_ENCODE) begin
            push         = full || i_last;
            o_job.n_data = full ? 3'd4 : cnt_after + 3'd1;
        end else begin
            push         = full || (i_last && cnt_after >= 3'd2);
            o_job.n_data = full ? 3'd3 : cnt_after - 3'd1;
        end

        n_cnt = (full || i_last) ? 2'd0 : cnt_after[1:0];
        n_pad = i_last ? 1'b0 : (r_pad || (r_mode == MODE_DECODE && i_byte == CHAR_PAD));
    end

    assign o_push = accept && push;

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
            r_cnt  <= 2'd0;
            r_pad  <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_mode;
            r_cnt  <= 2'd0;
            r_pad  <= 1'b0;
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_pad <= n_pad;
        end
    end

    // group bytes
    always_ff @(posedge i_clk) begin
        if (accept && stored) begin
            r_grp[r_cnt] <= i_byte;
        end
    end

endmodule

/* rtl/b64c_queue.sv */
// ----------------------------------------------------------------------------
// b64c_queue
// Short first-in first-out queue of groups between the front and the back.
// ----------------------------------------------------------------------------
module b64c_queue
    import b64c_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* rtl/b64c_back.sv */
// ----------------------------------------------------------------------------
// b64c_back
// Turns queued groups into result items, one per cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module b64c_back
    import b64c_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // queue side
    input  t_job       i_head,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    // result item
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic [1:0] r_idx;
    logic       r_vld;
    logic [7:0] r_byte;
    logic       r_last;

    logic       load;
    logic       take;
    logic [1:0] last_idx;
    logic [5:0] sext;
    logic [7:0] enc_out;
    logic [7:0] v0, v1, v2, v3;
    logic [7:0] dec_out;
    logic [7:0] n_byte;

    // result for the current position of the head group
    always_comb begin
        case (r_idx)
            2'd0:    sext = i_head.bytes[0][7:2];
            2'd1:    sext = {i_head.bytes[0][1:0], i_head.bytes[1][7:4]};
            2'd2:    sext = {i_head.bytes[1][3:0], i_head.bytes[2][7:6]};
            default: sext = i_head.bytes[2][5:0];
        endcase
        enc_out = ({1'b0, r_idx} < i_head.n_data) ? enc_char(sext) : CHAR_PAD;

        v0 = dec_sextet(i_head.bytes[0]);
        v1 = dec_sextet(i_head.bytes[1]);
        v2 = dec_sextet(i_head.bytes[2]);
        v3 = dec_sextet(i_head.bytes[3]);
        case (r_idx)
            2'd0:    dec_out = {v0[5:0], v1[5:4]};
            2'd1:    dec_out = {v1[3:0], v2[5:2]};
            default: dec_out = {v2[1:0], 6'b000000} + v3;
        endcase

        n_byte   = (i_head.mode == MODE_ENCODE) ? enc_out : dec_out;
        last_idx = (i_head.mode == MODE_ENCODE) ? 2'd3 : i_head.n_data[1:0] - 2'd1;
    end

    assign load  = !r_vld || i_ready;
    assign take  = load && !i_q_stat.empty;
    assign o_pop = take && (r_idx == last_idx);

    // position counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_vld <= 1'b0;
        end else begin
            if (load) begin
                r_vld <= !i_q_stat.empty;
            end
            if (take) begin
                r_idx <= (r_idx == last_idx) ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= n_byte;
            r_last <= i_head.last && (r_idx == last_idx);
        end
    end

    assign o_valid = r_vld;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

/* rtl/b64c_checker.sv */
// ----------------------------------------------------------------------------
// b64c_checker
// Port-level checks of the base64 codec, bound to the top level.
// ----------------------------------------------------------------------------
module b64c_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready
);

    // coming out of reset: nothing to send, room to take an item
    a_reset_clean : assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!o_m_tvalid && o_s_tready))
        else $error("codec not empty after reset");

    // a stalled result item holds
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled result item changed");

    // an empty output register means the queue cannot be full
    a_ready_when_drained : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output side is idle");

    // the mode register port never stalls
    a_cfg_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("mode write stalled");

endmodule

bind base64_codec_core b64c_checker u_b64c_checker (.*);

/* sim/tb_base64_codec_core.sv */
// ----------------------------------------------------------------------------
// tb_base64_codec_core
// Self-checking bench for the streaming base64 encoder and decoder.
// ----------------------------------------------------------------------------
// Bytes or characters go in as items on the input stream, and a behavioral
// predictor builds the items that should come out. Each output item is
// checked against the oldest prediction. Directed messages cover the group
// edges, padding, characters outside the alphabet and aborted groups. Random
// messages in both modes follow, and the last of them runs with no idling.
// ----------------------------------------------------------------------------
module tb_base64_codec_core
    import b64c_pkg::*;
();

    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_codec_item;

    // clock, reset and block ports
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_s_tvalid  = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata   = 8'h00;   // [7:0] in_byte
    logic       i_s_tlast   = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready  = 1'b0;
    logic [7:0] o_m_tdata;             // [7:0] out_byte
    logic       o_m_tlast;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data  = 1'b0;

    // predicted output items, oldest first
    t_codec_item pending_out[$];
    t_codec_item head_item;
    int          mismatches = 0;
    bit          quiet      = 1'b0;
    int          stall_left = 0;

    // predictor state
    logic       pred_mode     = MODE_ENCODE;
    logic [7:0] pred_held [4] = '{default: 8'h00};
    int         pred_count    = 0;
    bit         pred_pad      = 1'b0;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    base64_codec_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // sextet to alphabet character
    function automatic logic [7:0] char_of_sextet(input logic [5:0] s);
        if (s < 6'd26) begin
            return 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            return {2'b00, s} + 8'd71;
        end else if (s < 6'd62) begin
            return {2'b00, s} - 8'd4;
        end else if (s == 6'd62) begin
            return 8'h2B;
        end
        return 8'h2F;
    endfunction

    // alphabet character to sextet, 255 outside the alphabet
    function automatic int sextet_of_char(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'd71;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            return c + 8'd4;
        end else if (c == 8'h2B) begin
            return 62;
        end else if (c == 8'h2F) begin
            return 63;
        end
        return 255;
    endfunction

    // four characters from the held bytes, pad after the first nchars
    task automatic push_chars(input int nchars, input bit last);
        logic [5:0]  s [4];
        t_codec_item item;
        int          k;
        s[0] = pred_held[0][7:2];
        s[1] = {pred_held[0][1:0], pred_held[1][7:4]};
        s[2] = {pred_held[1][3:0], pred_held[2][7:6]};
        s[3] = pred_held[2][5:0];
        for (k = 0; k < 4; k++) begin
            item.data = (k < nchars) ? char_of_sextet(s[k]) : CHAR_PAD;
            item.last = last && (k == 3);
            pending_out.push_back(item);
        end
    endtask

    // first nbytes bytes decoded from the held characters, modulo 256
    task automatic push_bytes(input int nbytes, input bit last);
        int          v [4];
        int          t [3];
        t_codec_item item;
        int          k;
        for (k = 0; k < 4; k++) begin
            v[k] = sextet_of_char(pred_held[k]);
        end
        t[0] = (v[0] << 2) + ((v[1] & 32'h30) >> 4);
        t[1] = ((v[1] & 32'h0f) << 4) + ((v[2] & 32'h3c) >> 2);
        t[2] = ((v[2] & 32'h03) << 6) + v[3];
        for (k = 0; k < nbytes; k++) begin
            item.data = t[k][7:0];
            item.last = last && (k == nbytes - 1);
            pending_out.push_back(item);
        end
    endtask

    // expected output items of one accepted input item
    task automatic predict_item(input logic [7:0] b, input bit last);
        int n;
        int k;
        n = 0;
        if (pred_mode == MODE_ENCODE) begin
            pred_held[pred_count] = b;
            pred_count++;
            if (pred_count >= 3) begin
                push_chars(4, last);
                n = 4;
                pred_count = 0;
            end else if (last) begin
                pred_held[2] = 8'h00;
                if (pred_count == 1) begin
                    pred_held[1] = 8'h00;
                end
                push_chars(pred_count + 1, 1'b1);
                n = pred_count + 1;
            end
        end else begin
            // anything after a pad is dropped up to the end mark
            if (!pred_pad) begin
                if (b == CHAR_PAD) begin
                    pred_pad = 1'b1;
                end else begin
                    pred_held[pred_count] = b;
                    if (pred_count == 3) begin
                        push_bytes(3, last);
                        n = 3;
                        pred_count = 0;
                    end else begin
                        pred_count++;
                    end
                end
            end
            // short final group
            if (last && n == 0 && pred_count >= 2) begin
                for (k = pred_count; k < 4; k++) begin
                    pred_held[k] = 8'h00;
                end
                push_bytes(pred_count - 1, 1'b1);
            end
        end
        if (last) begin
            pred_count = 0;
            pred_pad = 1'b0;
        end
    endtask

    // send one item, at times with a random gap in front of it
    task automatic send_item(input logic [7:0] b, input bit last);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        predict_item(b, last);
    endtask

    task automatic send_text(input string s, input bit mark_last);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_item(s[i], mark_last && (i == s.len() - 1));
        end
    endtask

    // mode write, only once all predicted items are out and the block is quiet
    task automatic write_mode(input logic m);
        i_s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pred_mode  = m;
        pred_count = 0;
        pred_pad   = 1'b0;
    endtask

    // one and two byte tails, a full group with end mark, another two byte tail
    task automatic test_encode_edges();
        write_mode(MODE_ENCODE);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h4D, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h6E, 1'b1);
        send_item(8'h21, 1'b0);
        send_item(8'h80, 1'b1);
    endtask

    // a partial group is dropped by the mode write
    task automatic test_abort_partial();
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b0);
        write_mode(MODE_DECODE);
    endtask

    // alphabet edges, pad as end item, lone char, junk and chars after pad
    task automatic test_decode_edges();
        send_text("+/az", 1'b1);
        send_text("AZ0=", 1'b1);
        send_text("9", 1'b1);
        send_item(8'h42, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CHAR_PAD, 1'b0);
        send_item(8'h78, 1'b1);
    endtask

    // random byte messages
    task automatic test_random_encode(input int budget);
        int sent;
        int len;
        int i;
        write_mode(MODE_ENCODE);
        sent = 0;
        while (sent < budget) begin
            len = $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
                send_item(8'($urandom_range(0, 255)), i == len - 1);
            end
            sent += len;
        end
    endtask

    // mostly well-formed text, some truncated or with junk mixed in
    task automatic test_random_decode(input int budget);
        int         sent;
        int         len;
        int         npad;
        int         i;
        bit         noisy;
        logic [7:0] c;
        write_mode(MODE_DECODE);
        sent = 0;
        while (sent < budget) begin
            len   = 4 * $urandom_range(1, 3);
            npad  = $urandom_range(0, 5);
            if (npad > 3) begin
                npad = 0;
            end
            noisy = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                len = $urandom_range(1, len);
            end
            for (i = 0; i < len; i++) begin
                if (i >= len - npad) begin
                    c = CHAR_PAD;
                end else begin
                    c = char_of_sextet(6'($urandom_range(0, 63)));
                end
                if (noisy && $urandom_range(0, 2) == 0) begin
                    c = 8'($urandom_range(0, 255));
                end
                send_item(c, i == len - 1);
            end
            sent += len;
        end
    endtask

    // output stalls in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 18);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // compare each output item with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual out_byte %02h out_last %0b",
                         $time, o_m_tdata, o_m_tlast);
                mismatches++;
            end else begin
                head_item = pending_out.pop_front();
                if (o_m_tdata !== head_item.data) begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, head_item.data, o_m_tdata);
                    mismatches++;
                end
                if (o_m_tlast !== head_item.last) begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, head_item.last, o_m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_encode_edges();
        test_abort_partial();
        test_decode_edges();
        test_random_encode(30);
        test_random_decode(35);
        test_random_encode(30);
        quiet = 1'b1;
        test_random_decode(30);
        i_s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_out.size() == 0) begin
            $display("base64_codec_core regression: pass");
        end else begin
            $display("base64_codec_core regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(2 * LIMIT_CYCLES);
        $display("base64_codec_core regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/b64c_pkg.sv
rtl/b64c_front.sv
rtl/b64c_queue.sv
rtl/b64c_back.sv
rtl/base64_codec_core.sv
rtl/b64c_checker.sv
sim/tb_base64_codec_core.sv
